FILE: hdl/tee_pkg.sv
// Package for the tagged element extractor: element walk phases, result kinds,
// and the result record passed between the parser and the output buffer.
// No dependencies.
package tee_pkg;

    typedef enum logic [1:0] {
        PH_ID  = 2'd0,
        PH_LEN = 2'd1,
        PH_VAL = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        KIND_VALUE     = 2'd0,
        KIND_EMPTY     = 2'd1,
        KIND_NOT_FOUND = 2'd2,
        KIND_TRUNCATED = 2'd3
    } t_kind;

    typedef struct packed {
        logic [7:0] value_byte;
        t_kind      kind;
        logic       last_of_value;
    } t_result;

endpackage

FILE: hdl/tee_if.sv
// Valid/ready stream interfaces for the tagged element extractor:
// the byte input channel and the result output channel. No dependencies.
interface tee_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       region_end;

    modport source (output valid, output data_byte, output region_end, input ready);
    modport sink   (input valid, input data_byte, input region_end, output ready);
endinterface

interface tee_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] value_byte;
    logic [1:0] kind;
    logic       last_of_value;

    modport source (output valid, output value_byte, output kind, output last_of_value,
                    input ready);
    modport sink   (input valid, input value_byte, input kind, input last_of_value,
                    output ready);
endinterface

FILE: hdl/tagged_element_extract_core.sv
// Top level of the tagged element extractor: parser and output buffer.
// Depends on tee_pkg, tee_if, tee_parser, tee_out_buf.
//
// Takes the bytes of a management frame's tagged-parameter region and walks
// its id/length/value elements; value bytes of the first element whose id
// equals the target tag come out as kind 0, the last one flagged, and a frame
// closes with exactly one status-or-final result (empty, not found, truncated)
// unless the full value or an empty result was already sent. Results are
// registered in the output register or, behind a stalled one, in a skid stage
// that keeps input ready high through a single output stall, so the sustained
// rate is one byte per cycle while results are drained. The target tag is
// written through i_cfg_we/i_cfg_wdata and is used from the next id byte on.
module tagged_element_extract_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    tee_in_if.sink     i_in,
    tee_out_if.source  o_out
);
    import tee_pkg::*;

    logic    take;
    logic    can_take;
    logic    res_valid;
    t_result res;
    t_result out_res;

    assign i_in.ready = can_take;
    assign take       = i_in.valid && can_take;

    tee_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_take       (take),
        .i_data_byte  (i_in.data_byte),
        .i_region_end (i_in.region_end),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    tee_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (take && res_valid),
        .i_res      (res),
        .o_can_take (can_take),
        .o_valid    (o_out.valid),
        .o_res      (out_res),
        .i_ready    (o_out.ready)
    );

    assign o_out.value_byte    = out_res.value_byte;
    assign o_out.kind          = out_res.kind;
    assign o_out.last_of_value = out_res.last_of_value;
endmodule

FILE: hdl/tee_parser.sv
// Element walk: per-frame state registers, target tag register and the
// combinational next-state and result logic. Depends on tee_pkg.
module tee_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [7:0]       i_cfg_wdata,
    input  logic             i_take,
    input  logic [7:0]       i_data_byte,
    input  logic             i_region_end,
    output logic             o_res_valid,
    output tee_pkg::t_result o_res
);
    import tee_pkg::*;

    logic [7:0] r_target;
    t_phase     r_phase,      n_phase;
    logic [7:0] r_bytes_left, n_bytes_left;
    logic       r_is_match,   n_is_match;
    logic       r_done,       n_done;

    logic       emitted;
    logic       emitted_last;
    logic [7:0] e_vb;
    t_kind      e_kind;
    logic [7:0] dec_left;

    always_comb begin
        n_phase      = r_phase;
        n_bytes_left = r_bytes_left;
        n_is_match   = r_is_match;
        n_done       = r_done;
        emitted      = 1'b0;
        emitted_last = 1'b0;
        e_vb         = 8'd0;
        e_kind       = KIND_VALUE;
        dec_left     = r_bytes_left - 8'd1;
        o_res_valid  = 1'b0;
        o_res        = '0;

        case (r_phase)
            PH_LEN: begin
                n_bytes_left = i_data_byte;
                if (i_data_byte == 8'd0) begin
                    if (r_is_match) begin
                        emitted      = 1'b1;
                        emitted_last = 1'b1;
                        e_kind       = KIND_EMPTY;
                        n_done       = 1'b1;
                        n_is_match   = 1'b0;
                    end
                    n_phase = PH_ID;
                end else begin
                    n_phase = PH_VAL;
                end
            end
            PH_VAL: begin
                n_bytes_left = dec_left;
                if (r_is_match) begin
                    emitted = 1'b1;
                    e_vb    = i_data_byte;
                    if (dec_left == 8'd0) begin
                        emitted_last = 1'b1;
                        n_done       = 1'b1;
                        n_is_match   = 1'b0;
                    end
                end
                if (dec_left == 8'd0) begin
                    n_phase = PH_ID;
                end
            end
            default: begin
                // id byte; the unused phase code lands here too
                n_is_match = !r_done && (i_data_byte == r_target);
                n_phase    = PH_LEN;
            end
        endcase

        if (!i_region_end) begin
            o_res_valid = emitted;
            o_res       = '{value_byte: e_vb, kind: e_kind, last_of_value: emitted_last};
        end else begin
            // settle the frame outcome; a non-final matched byte becomes truncation
            if (emitted && emitted_last) begin
                o_res_valid = 1'b1;
                o_res       = '{value_byte: e_vb, kind: e_kind, last_of_value: 1'b1};
            end else if (n_is_match) begin
                o_res_valid = 1'b1;
                o_res       = '{value_byte: 8'd0, kind: KIND_TRUNCATED, last_of_value: 1'b1};
            end else if (!n_done) begin
                o_res_valid = 1'b1;
                o_res       = '{value_byte: 8'd0, kind: KIND_NOT_FOUND, last_of_value: 1'b1};
            end
            n_phase      = PH_ID;
            n_bytes_left = 8'd0;
            n_is_match   = 1'b0;
            n_done       = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target     <= 8'd0;
            r_phase      <= PH_ID;
            r_bytes_left <= 8'd0;
            r_is_match   <= 1'b0;
            r_done       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_target <= i_cfg_wdata;
            end
            if (i_take) begin
                r_phase      <= n_phase;
                r_bytes_left <= n_bytes_left;
                r_is_match   <= n_is_match;
                r_done       <= n_done;
            end
        end
    end
endmodule

FILE: hdl/tee_out_buf.sv
// Result register with a skid stage, so a byte can be taken in the same
// cycle a stalled result waits. Depends on tee_pkg.
module tee_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  tee_pkg::t_result i_res,
    output logic             o_can_take,
    output logic             o_valid,
    output tee_pkg::t_result o_res,
    input  logic             i_ready
);
    import tee_pkg::*;

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;
    logic    pop;

    assign pop        = r_main_valid && i_ready;
    assign o_can_take = !r_skid_valid;
    assign o_valid    = r_main_valid;
    assign o_res      = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            // no push while the skid is full
            if (pop) begin
                r_main_valid <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_main_valid || pop) begin
                r_main_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (pop) begin
            r_main_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_main <= r_skid;
            end
        end else if (i_push) begin
            if (!r_main_valid || pop) begin
                r_main <= i_res;
            end else begin
                r_skid <= i_res;
            end
        end
    end
endmodule

FILE: hdl/tee_checker.sv
// Port-level checks for tagged_element_extract_core, and the bind that
// attaches them. Depends on tee_pkg.
module tee_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_value_byte,
    input logic [1:0] i_kind,
    input logic       i_last
);
    import tee_pkg::*;

    logic out_stall;
    assign out_stall = i_out_valid && !i_out_ready;

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_stall |=> i_out_valid)
        else $error("result valid dropped during stall");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_stall |=> $stable(i_value_byte) && $stable(i_kind) && $stable(i_last))
        else $error("result payload changed during stall");

    a_status_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_kind != KIND_VALUE) |-> i_last)
        else $error("status result not marked last");

    a_status_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_kind != KIND_VALUE) |-> (i_value_byte == 8'd0))
        else $error("status result carries a nonzero value byte");
endmodule

bind tagged_element_extract_core tee_checker u_tee_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_value_byte (o_out.value_byte),
    .i_kind       (o_out.kind),
    .i_last       (o_out.last_of_value)
);

FILE: bench/tagged_element_extract_core_tb.sv
// Testbench for tagged_element_extract_core: directed and random byte streams
// of TLV frames go in; every result is checked against an in-bench model of the
// element walk. Depends on tee_pkg, tee_if and the RTL of the core.
module tagged_element_extract_core_tb;
    import tee_pkg::*;

    typedef struct {
        logic [7:0] data;
        logic       fin;
    } t_region_byte;

    // directed frames, bit 8 marks the end of the region
    localparam logic [8:0] DIRECTED [0:22] = '{
        // empty match, then a later element is only skipped
        9'h000, 9'h000, 9'h0FF, 9'h001, 9'h1AA,
        // skip a foreign element, full value ends on the region's last byte
        9'h005, 9'h002, 9'h011, 9'h022, 9'h000, 9'h002, 9'h0FF, 9'h100,
        // region ends on the matched id byte
        9'h100,
        // region ends on a nonzero length byte of the match
        9'h000, 9'h103,
        // region ends inside the matched value
        9'h000, 9'h002, 9'h17E,
        // region ends inside an element that is not of interest
        9'h033, 9'h101,
        // empty match on the region's last byte
        9'h000, 9'h100
    };

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [7:0] i_cfg_wdata;

    tee_in_if  in_if ();
    tee_out_if out_if ();

    tagged_element_extract_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    t_region_byte byte_q[$];
    t_result      results_due[$];

    // model of the element walk
    logic [7:0] target_tag;
    logic [1:0] elem_phase;
    logic [7:0] value_left;
    logic       in_target;
    logic       outcome_sent;

    int in_idle_pct;
    int out_idle_pct;
    int bytes_queued;
    int bytes_accepted;
    int errors;

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    function automatic void walk_byte(input logic [7:0] b, input logic fin);
        logic    got;
        logic    got_last;
        t_result r;
        got      = 1'b0;
        got_last = 1'b0;
        r        = '0;
        case (elem_phase)
            PH_LEN: begin
                value_left = b;
                if (b == 8'd0) begin
                    if (in_target) begin
                        got          = 1'b1;
                        got_last     = 1'b1;
                        r.kind       = KIND_EMPTY;
                        outcome_sent = 1'b1;
                        in_target    = 1'b0;
                    end
                    elem_phase = PH_ID;
                end else begin
                    elem_phase = PH_VAL;
                end
            end
            PH_VAL: begin
                value_left = value_left - 8'd1;
                if (in_target) begin
                    got          = 1'b1;
                    r.value_byte = b;
                    r.kind       = KIND_VALUE;
                    if (value_left == 8'd0) begin
                        got_last     = 1'b1;
                        outcome_sent = 1'b1;
                        in_target    = 1'b0;
                    end
                end
                if (value_left == 8'd0) elem_phase = PH_ID;
            end
            default: begin
                in_target  = !outcome_sent && (b == target_tag);
                elem_phase = PH_LEN;
            end
        endcase

        if (!fin) begin
            if (got) begin
                r.last_of_value = got_last;
                results_due.push_back(r);
            end
        end else begin
            // region closes: at most one final result, then re-arm
            if (got && got_last) begin
                r.last_of_value = 1'b1;
                results_due.push_back(r);
            end else if (in_target) begin
                r = '0;
                r.kind = KIND_TRUNCATED;
                r.last_of_value = 1'b1;
                results_due.push_back(r);
            end else if (!outcome_sent) begin
                r = '0;
                r.kind = KIND_NOT_FOUND;
                r.last_of_value = 1'b1;
                results_due.push_back(r);
            end
            elem_phase   = PH_ID;
            value_left   = 8'd0;
            in_target    = 1'b0;
            outcome_sent = 1'b0;
        end
    endfunction

    function automatic void queue_byte(input logic [7:0] b, input logic fin);
        t_region_byte item;
        item.data = b;
        item.fin  = fin;
        byte_q.push_back(item);
        bytes_queued = bytes_queued + 1;
    endfunction

    // one frame: mostly well-formed element lists, some cut short, some noise
    function automatic int queue_random_frame();
        logic [7:0]  frame[$];
        int          n_elem;
        int          len;
        int          cut;
        int          e;
        int          k;
        int unsigned roll;
        n_elem = $urandom_range(0, 4);
        for (e = 0; e < n_elem; e++) begin
            if ($urandom_range(99) < 35) frame.push_back(target_tag);
            else frame.push_back(8'($urandom_range(255)));
            roll = $urandom_range(99);
            if (roll < 1) len = 255;
            else if (roll < 4) len = $urandom_range(7, 64);
            else len = $urandom_range(0, 6);
            frame.push_back(8'(len));
            for (k = 0; k < len; k++) begin
                if ($urandom_range(9) == 0) frame.push_back(target_tag);
                else frame.push_back(8'($urandom_range(255)));
            end
        end
        if (frame.size() == 0) frame.push_back(8'($urandom_range(255)));

        roll = $urandom_range(99);
        if (roll < 70) begin
            cut = frame.size();
        end else if (roll < 90) begin
            cut = $urandom_range(1, frame.size());
        end else begin
            frame.delete();
            cut = $urandom_range(1, 8);
            for (k = 0; k < cut; k++) frame.push_back(8'($urandom_range(255)));
        end
        for (k = 0; k < cut; k++) queue_byte(frame[k], k == cut - 1);
        return cut;
    endfunction

    task automatic wait_drained();
        while (bytes_accepted != bytes_queued || results_due.size() != 0)
            @(posedge i_clk);
        // bytes that produce no result may still be inside the core
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_target(input logic [7:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        target_tag = v;
    endtask

    // input driver
    always @(posedge i_clk) begin : drive_bytes
        t_region_byte nxt;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                walk_byte(in_if.data_byte, in_if.region_end);
                bytes_accepted = bytes_accepted + 1;
            end
            if (!in_if.valid || in_if.ready) begin
                if (byte_q.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
                    nxt = byte_q.pop_front();
                    in_if.valid      <= 1'b1;
                    in_if.data_byte  <= nxt.data;
                    in_if.region_end <= nxt.fin;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(99) >= out_idle_pct);
        end
    end

    // result monitor
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (results_due.size() == 0) begin
                $display("%0t: unexpected result value_byte=%h kind=%0d last=%b", $time,
                         out_if.value_byte, out_if.kind, out_if.last_of_value);
                errors = errors + 1;
            end else begin
                want = results_due.pop_front();
                if (out_if.value_byte !== want.value_byte) begin
                    $display("%0t: value_byte expected %h actual %h", $time,
                             want.value_byte, out_if.value_byte);
                    errors = errors + 1;
                end
                if (out_if.kind !== want.kind) begin
                    $display("%0t: kind expected %0d actual %0d", $time,
                             want.kind, out_if.kind);
                    errors = errors + 1;
                end
                if (out_if.last_of_value !== want.last_of_value) begin
                    $display("%0t: last_of_value expected %b actual %b", $time,
                             want.last_of_value, out_if.last_of_value);
                    errors = errors + 1;
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : run_phases
        logic [7:0] tags [0:5];
        int         p;
        int         n;
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_wdata      = 8'd0;
        in_if.valid      = 1'b0;
        in_if.data_byte  = 8'd0;
        in_if.region_end = 1'b0;
        out_if.ready     = 1'b0;
        target_tag       = 8'd0;
        elem_phase       = PH_ID;
        value_left       = 8'd0;
        in_target        = 1'b0;
        outcome_sent     = 1'b0;
        in_idle_pct      = 20;
        out_idle_pct     = 54;
        bytes_queued     = 0;
        bytes_accepted   = 0;
        errors           = 0;
        tags[0] = 8'hFF;
        tags[1] = 8'($urandom_range(1, 254));
        tags[2] = 8'h00;
        tags[3] = 8'($urandom_range(1, 254));
        tags[4] = 8'hA5;
        tags[5] = 8'($urandom_range(1, 254));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (n = 0; n < 23; n++) queue_byte(DIRECTED[n][7:0], DIRECTED[n][8]);
        wait_drained();

        for (p = 0; p < 6; p++) begin
            case (p / 2)
                0: begin
                    in_idle_pct  = 20;
                    out_idle_pct = 54;
                end
                1: begin
                    in_idle_pct  = 54;
                    out_idle_pct = 20;
                end
                default: begin
                    in_idle_pct  = 0;
                    out_idle_pct = 0;
                end
            endcase
            set_target(tags[p]);
            n = 0;
            while (n < 155) n = n + queue_random_frame();
            wait_drained();
        end

        repeat (10) @(posedge i_clk);
        if (results_due.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, results_due.size());
            errors = errors + 1;
        end
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
